// ===== rtl/flba_pkg.sv =====
// ----------------------------------------------------------------------------
// flba_pkg
// Shared types and constants of the free-list block allocator.
// ----------------------------------------------------------------------------
package flba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int BYTES_W    = 17;
    localparam int OFFSET_W   = 24;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [1:0]        status_t;

    localparam status_t STATUS_GRANTED  = 2'd0;
    localparam status_t STATUS_EMPTY    = 2'd1;
    localparam status_t STATUS_RELEASED = 2'd2;
    localparam status_t STATUS_IGNORED  = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

endpackage

// ===== rtl/flba_if.sv =====
// ----------------------------------------------------------------------------
// flba_if
// Request and response channels of the free-list block allocator.
// ----------------------------------------------------------------------------
interface flba_req_if import flba_pkg::*;
    ;
    logic valid;
    logic ready;
    logic command;
    logic release_present;
    idx_t release_index;

    modport source
    (
        output valid, command, release_present, release_index,
        input  ready
    );

    modport sink
    (
        input  valid, command, release_present, release_index,
        output ready
    );
endinterface

interface flba_rsp_if import flba_pkg::*;
    ;
    logic                valid;
    logic                ready;
    status_t             status;
    idx_t                grant_index;
    logic [OFFSET_W-1:0] grant_offset;
    link_t               blocks_in_use;

    modport source
    (
        output valid, status, grant_index, grant_offset, blocks_in_use,
        input  ready
    );

    modport sink
    (
        input  valid, status, grant_index, grant_offset, blocks_in_use,
        output ready
    );
endinterface

// ===== rtl/free_list_block_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_block_allocator
// Fixed-size block pool with a LIFO free chain kept in a link memory.
// ----------------------------------------------------------------------------
// A request transaction has an accept step and an execute step: the accept
// cycle reads the link of the current head from the single-port link memory,
// the execute state uses that link, updates head, count and memory, and loads
// the response register. A new request is taken while a response still waits;
// the block stalls in its execute state only while the response register is
// held. Link entries unwritten since reset or the last pool_blocks write read
// as the rebuilt chain (tracked by per-entry valid bits): no clearing pass.
// Writing pool_blocks rebuilds the chain 0..n-1 at once from cfg_data[8:0];
// 0 reads as 1, 257..511 as 256; grant_offset = index * block_bytes mod 2^24.
module free_list_block_allocator
    import flba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    flba_req_if.sink             req,
    flba_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                state_reg, state_next;
    link_t               head_reg, head_next;
    link_t               count_reg, count_next;
    link_t               pool_reg;
    logic [BYTES_W-1:0]  bytes_reg;

    logic                cmd_reg;
    logic                present_reg;
    idx_t                rel_reg;

    link_t               link_mem [MAX_BLOCKS];
    link_t               link_rd_reg;
    logic [MAX_BLOCKS-1:0] link_vld_reg;
    logic                vld_rd_reg;

    logic                out_valid_reg;
    status_t             status_reg;
    idx_t                gidx_reg;
    logic [OFFSET_W-1:0] goff_reg;
    link_t               used_reg;

    logic                accept;
    logic                out_free;
    logic                exec_go;
    logic                head_ok;
    logic                rel_ok;
    logic                rel_write;
    link_t               head_succ;
    link_t               dflt_link;
    link_t               link_val;
    logic [IDX_W+BYTES_W-1:0] prod;
    link_t               pool_wr;
    status_t             status_next;
    idx_t                gidx_next;
    logic [OFFSET_W-1:0] goff_next;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign exec_go   = (state_reg == ST_EXEC) && out_free;

    assign head_ok   = head_reg < pool_reg;
    assign rel_ok    = present_reg && ({1'b0, rel_reg} < pool_reg);
    assign rel_write = exec_go && (cmd_reg == CMD_RELEASE) && rel_ok;

    assign head_succ = {1'b0, head_reg[IDX_W-1:0]} + LINK_W'(1);
    assign dflt_link = (head_succ < pool_reg) ? head_succ : NULL_LINK;
    assign link_val  = vld_rd_reg ? link_rd_reg : dflt_link;

    assign prod = {{BYTES_W{1'b0}}, head_reg[IDX_W-1:0]}
                * {{IDX_W{1'b0}}, bytes_reg};

    always_comb
    begin
        if (cfg_data[LINK_W-1:0] == '0)
            pool_wr = LINK_W'(1);
        else if (cfg_data[LINK_W-1:0] > NULL_LINK)
            pool_wr = NULL_LINK;
        else
            pool_wr = cfg_data[LINK_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STATUS_IGNORED;
        gidx_next   = '0;
        goff_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (head_ok)
                    begin
                        status_next = STATUS_GRANTED;
                        gidx_next   = head_reg[IDX_W-1:0];
                        goff_next   = prod[OFFSET_W-1:0];
                        head_next   = link_val;
                        if (count_reg < NULL_LINK)
                            count_next = count_reg + LINK_W'(1);
                    end
                    else
                        status_next = STATUS_EMPTY;
                end
                else if (rel_ok)
                begin
                    status_next = STATUS_RELEASED;
                    head_next   = {1'b0, rel_reg};
                    if (count_reg != '0)
                        count_next = count_reg - LINK_W'(1);
                end
                if (!exec_go)
                begin
                    head_next  = head_reg;
                    count_next = count_reg;
                end
                else
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we && (cfg_index == REG_POOL_BLOCKS))
        begin
            head_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pool_reg      <= NULL_LINK;
            bytes_reg     <= BYTES_W'(64);
            link_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (exec_go)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && (cfg_index == REG_POOL_BLOCKS))
            begin
                pool_reg     <= pool_wr;
                link_vld_reg <= '0;
            end
            else if (rel_write)
                link_vld_reg[rel_reg] <= 1'b1;
            if (cfg_we && (cfg_index == REG_BLOCK_BYTES))
                bytes_reg <= cfg_data[BYTES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req.command;
            present_reg <= req.release_present;
            rel_reg     <= req.release_index;
            vld_rd_reg  <= link_vld_reg[head_reg[IDX_W-1:0]];
        end
        if (exec_go)
        begin
            status_reg <= status_next;
            gidx_reg   <= gidx_next;
            goff_reg   <= goff_next;
            used_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rel_write)
            link_mem[rel_reg] <= head_reg;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.grant_index   = gidx_reg;
    assign rsp.grant_offset  = goff_reg;
    assign rsp.blocks_in_use = used_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NULL_LINK)
        else $error("in-use count above pool maximum");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_LINK)
        else $error("free chain head out of range");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !(cfg_we && (cfg_index == REG_POOL_BLOCKS)) |=> state_reg == ST_EXEC)
        else $error("accepted transaction not executed");

    a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STATUS_GRANTED)
        |-> (gidx_reg == '0) && (goff_reg == '0))
        else $error("non-grant response carries a block");

endmodule
